// ===== rtl/wevf_pkg.sv =====
// ----------------------------------------------------------------------------
// wevf_pkg: shared types, constants and helpers
// Field widths, configuration register indexes, lane control word and the
// signed 32-bit saturation used by the velocity filter lanes.
// ----------------------------------------------------------------------------
`default_nettype none

package wevf_pkg;

  localparam int DELTA_W   = 16;  // encoder delta per tick
  localparam int D_W       = 17;  // delta after optional negation
  localparam int POS_W     = 32;
  localparam int SPD_W     = 32;
  localparam int MASK_W    = 4;   // sign mask covers FL FR RL RR only
  localparam int VPC_W     = 24;
  localparam int ALPHA_W   = 17;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 24;
  localparam int PROD1_W   = 42;  // d * velocity_per_count
  localparam int ERR_W     = 33;  // raw - filtered
  localparam int PROD2_W   = 51;  // alpha * err
  localparam int SUM_W     = 35;  // filtered + (prod2 >>> 16)
  localparam int FRAC_W    = 16;

  localparam logic [CFG_IDX_W-1:0] REG_SIGN_MASK    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VEL_PER_CNT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_ALPHA = 2'd2;

  localparam logic [MASK_W-1:0]  SIGN_MASK_RST = 4'd5;
  localparam logic [VPC_W-1:0]   VPC_RST       = 24'd765950;
  localparam logic [ALPHA_W-1:0] ALPHA_RST     = 17'd5243;

  typedef struct packed {
    logic ld;    // take a new word, form delta and first product
    logic mul;   // form error and second product
    logic upd;   // commit position and filtered speed
  } lane_ctl_t;

  // Clamp a wide signed value to the signed 32-bit range.
  function automatic logic [31:0] sat32(input logic [PROD2_W-1:0] v);
    logic [31:0] r;
    if (!v[PROD2_W-1] && (|v[PROD2_W-2:31])) begin
      r = 32'h7FFF_FFFF;
    end else if (v[PROD2_W-1] && !(&v[PROD2_W-2:31])) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/wevf_lane.sv =====
// ----------------------------------------------------------------------------
// wevf_lane: per-wheel position accumulator and velocity low-pass filter
// Three steps per word: scale the delta, multiply the error by alpha, then
// commit the wrapping position and the saturated filtered speed.
// ----------------------------------------------------------------------------
`default_nettype none

module wevf_lane (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire  wevf_pkg::lane_ctl_t            ctl,
  input  wire                                  neg,
  input  wire  [wevf_pkg::VPC_W-1:0]           vel_per_count,
  input  wire  [wevf_pkg::ALPHA_W-1:0]         alpha,
  input  wire  [wevf_pkg::DELTA_W-1:0]         delta,
  output logic [wevf_pkg::POS_W-1:0]           pos_nxt,
  output logic [wevf_pkg::SPD_W-1:0]           spd_nxt
);

  logic        [wevf_pkg::POS_W-1:0]   pos_r;
  logic        [wevf_pkg::SPD_W-1:0]   spd_r;
  logic signed [wevf_pkg::D_W-1:0]     d_r,     d_nxt,  d_ext;
  logic signed [wevf_pkg::PROD1_W-1:0] prod1_r, prod1_nxt;
  logic signed [wevf_pkg::PROD2_W-1:0] prod2_r, prod2_nxt;
  logic        [wevf_pkg::SPD_W-1:0]   raw;
  logic signed [wevf_pkg::ERR_W-1:0]   err;
  logic signed [wevf_pkg::SUM_W-1:0]   sum;

  always_comb begin
    d_ext     = {delta[wevf_pkg::DELTA_W-1], delta};
    d_nxt     = neg ? -d_ext : d_ext;
    prod1_nxt = d_nxt * $signed({1'b0, vel_per_count});

    raw       = wevf_pkg::sat32({{(wevf_pkg::PROD2_W-wevf_pkg::PROD1_W)
                                  {prod1_r[wevf_pkg::PROD1_W-1]}}, prod1_r});
    err       = $signed({raw[31], raw}) - $signed({spd_r[31], spd_r});
    prod2_nxt = err * $signed({1'b0, alpha});

    // arithmetic shift by the fraction width: take the upper bits
    sum       = $signed(prod2_r[wevf_pkg::PROD2_W-1:wevf_pkg::FRAC_W])
              + $signed({{(wevf_pkg::SUM_W-wevf_pkg::SPD_W){spd_r[31]}}, spd_r});
    spd_nxt   = wevf_pkg::sat32({{(wevf_pkg::PROD2_W-wevf_pkg::SUM_W)
                                  {sum[wevf_pkg::SUM_W-1]}}, sum});
    pos_nxt   = pos_r + {{(wevf_pkg::POS_W-wevf_pkg::D_W){d_r[wevf_pkg::D_W-1]}}, d_r};
  end

  always_ff @(posedge clk) begin
    if (ctl.ld) begin
      d_r     <= d_nxt;
      prod1_r <= prod1_nxt;
    end
    if (ctl.mul) begin
      prod2_r <= prod2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      spd_r <= '0;
    end else if (ctl.upd) begin
      pos_r <= pos_nxt;
      spd_r <= spd_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/wevf_merge.sv =====
// ----------------------------------------------------------------------------
// wevf_merge: result register combining all lanes into one output word
// Packs every position then every filtered speed and holds the word until
// the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module wevf_merge #(
  parameter int WHEELS = 4
) (
  input  wire                                         clk,
  input  wire                                         rst_n,
  input  wire                                         load,
  input  wire  [WHEELS-1:0][wevf_pkg::POS_W-1:0]      pos,
  input  wire  [WHEELS-1:0][wevf_pkg::SPD_W-1:0]      spd,
  output logic                                        out_free,
  output logic                                        out_tvalid,
  input  wire                                         out_tready,
  output logic [WHEELS*(wevf_pkg::POS_W+wevf_pkg::SPD_W)-1:0] out_tdata
);

  localparam int POS_BITS = WHEELS * wevf_pkg::POS_W;

  logic                                  valid_r;
  logic [WHEELS*(wevf_pkg::POS_W+wevf_pkg::SPD_W)-1:0] data_r;

  assign out_free   = !valid_r || out_tready;
  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r[POS_BITS-1:0]            <= pos;
      data_r[$bits(data_r)-1:POS_BITS] <= spd;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/wheel_encoder_velocity_filter_top.sv =====
// ----------------------------------------------------------------------------
// wheel_encoder_velocity_filter_top: four-wheel position and speed filter
// Usage:
//   in_*  : one word per tick, WHEELS signed 16-bit encoder deltas.
//   out_* : one word per tick, WHEELS 32-bit positions then WHEELS 32-bit
//           filtered speeds (Q16.16 rad/s).
//   cfg_* : register writes (sign mask, velocity per count, filter alpha),
//           always ready; write only while no tick is in flight.
// Steps: the accepting edge loads the scale product, then the alpha product
// is registered, and the commit loads the new positions, speeds and the
// result word; the result word is valid once the commit has happened.
// All wheels run in parallel lanes, so a new tick is accepted only after
// the three lane steps (two registered multipliers and the commit) are done.
// The result register frees the input side: a new tick is taken while the
// previous result still waits. If the receiver stalls, the commit step holds
// (state is not updated) until the result register is free.
// Reset clears positions and filtered speeds to zero and loads the register
// defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module wheel_encoder_velocity_filter_top #(
  parameter int WHEELS = 4
) (
  input  wire                                     clk,
  input  wire                                     rst_n,
  // fields from bit 0: delta_front_left, delta_front_right, delta_rear_left,
  // delta_rear_right (16 bits each, one per wheel)
  input  wire  [WHEELS*wevf_pkg::DELTA_W-1:0]     in_tdata,
  input  wire                                     in_tvalid,
  output logic                                    in_tready,
  // fields from bit 0: position_front_left .. position_rear_right (32 each),
  // then speed_front_left .. speed_rear_right (32 each)
  output logic [WHEELS*(wevf_pkg::POS_W+wevf_pkg::SPD_W)-1:0] out_tdata,
  output logic                                    out_tvalid,
  input  wire                                     out_tready,
  input  wire                                     cfg_valid,
  output logic                                    cfg_ready,
  input  wire  [wevf_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  wire  [wevf_pkg::CFG_DAT_W-1:0]          cfg_data
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_UPD
  } state_t;

  state_t                          state_r, state_nxt;
  logic [wevf_pkg::MASK_W-1:0]     sign_mask_r;
  logic [wevf_pkg::VPC_W-1:0]      vpc_r;
  logic [wevf_pkg::ALPHA_W-1:0]    alpha_r;
  wevf_pkg::lane_ctl_t             ctl;
  logic                            out_free;
  logic [WHEELS-1:0][wevf_pkg::POS_W-1:0] pos_nxt;
  logic [WHEELS-1:0][wevf_pkg::SPD_W-1:0] spd_nxt;

  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sign_mask_r <= wevf_pkg::SIGN_MASK_RST;
      vpc_r       <= wevf_pkg::VPC_RST;
      alpha_r     <= wevf_pkg::ALPHA_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        wevf_pkg::REG_SIGN_MASK:    sign_mask_r <= cfg_data[wevf_pkg::MASK_W-1:0];
        wevf_pkg::REG_VEL_PER_CNT:  vpc_r       <= cfg_data[wevf_pkg::VPC_W-1:0];
        wevf_pkg::REG_FILTER_ALPHA: alpha_r     <= cfg_data[wevf_pkg::ALPHA_W-1:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          ctl.ld    = 1'b1;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        ctl.mul   = 1'b1;
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        // hold until the result register can take the word
        if (out_free) begin
          ctl.upd   = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  for (genvar gi = 0; gi < WHEELS; gi++) begin : g_lane
    logic neg;
    if (gi < wevf_pkg::MASK_W) begin : g_mask
      assign neg = sign_mask_r[gi];
    end else begin : g_nomask
      assign neg = 1'b0;
    end

    wevf_lane u_lane (
      .clk           (clk),
      .rst_n         (rst_n),
      .ctl           (ctl),
      .neg           (neg),
      .vel_per_count (vpc_r),
      .alpha         (alpha_r),
      .delta         (in_tdata[gi*wevf_pkg::DELTA_W +: wevf_pkg::DELTA_W]),
      .pos_nxt       (pos_nxt[gi]),
      .spd_nxt       (spd_nxt[gi])
    );
  end

  wevf_merge #(
    .WHEELS (WHEELS)
  ) u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (ctl.upd),
    .pos        (pos_nxt),
    .spd        (spd_nxt),
    .out_free   (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire

// ===== rtl/wevf_checker.sv =====
// ----------------------------------------------------------------------------
// wevf_checker: port-level checks for the wheel velocity filter
// Watches the stream handshakes and the one-tick-at-a-time pacing.
// ----------------------------------------------------------------------------
`default_nettype none

module wevf_checker #(
  parameter int WHEELS = 4
) (
  input wire                                     clk,
  input wire                                     rst_n,
  input wire                                     in_tvalid,
  input wire                                     in_tready,
  input wire [WHEELS*(wevf_pkg::POS_W+wevf_pkg::SPD_W)-1:0] out_tdata,
  input wire                                     out_tvalid,
  input wire                                     out_tready
);

  // a stalled result word stays offered
  a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result word dropped while stalled");

  // a stalled result word does not change
  a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result word changed while stalled");

  // a taken tick keeps the input closed through the multiply and commit states
  a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready ##1 !in_tready)
    else $error("input reopened before the tick finished");

  // reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind wheel_encoder_velocity_filter_top wevf_checker #(
  .WHEELS (WHEELS)
) u_wevf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tdata  (out_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);

`default_nettype wire
